FILE: hdl/lru_kv_pkg.sv
// Package for the LRU key-value cache with per-entry expiry.
// Holds sizes, request codes and derived widths; no dependencies.
package lru_kv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int TIME_BITS  = 48;
    localparam int TTL_BITS   = 32;
    localparam int COUNT_W    = 5;
    localparam int CAP_W      = 5;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);

    localparam logic [1:0] REQ_SET    = 2'd0;
    localparam logic [1:0] REQ_GET    = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_PURGE  = 2'd3;

endpackage

FILE: hdl/lru_kv_req_if.sv
// Request channel of the LRU key-value cache.
// Depends on lru_kv_pkg for field widths.
interface lru_kv_req_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         req_type;
    logic [lru_kv_pkg::KEY_BITS-1:0]    key;
    logic [lru_kv_pkg::VALUE_BITS-1:0]  write_value;
    logic [lru_kv_pkg::TTL_BITS-1:0]    ttl;
    logic [lru_kv_pkg::TIME_BITS-1:0]   now;

    modport source (output valid, req_type, key, write_value, ttl, now, input ready);
    modport sink   (input valid, req_type, key, write_value, ttl, now, output ready);
endinterface

FILE: hdl/lru_kv_rsp_if.sv
// Response channel of the LRU key-value cache.
// Depends on lru_kv_pkg for field widths.
interface lru_kv_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic [lru_kv_pkg::VALUE_BITS-1:0]  read_value;
    logic [lru_kv_pkg::COUNT_W-1:0]     entry_count;

    modport source (output valid, hit, read_value, entry_count, input ready);
    modport sink   (input valid, hit, read_value, entry_count, output ready);
endinterface

FILE: hdl/lru_ttl_key_value_cache.sv
// Top level of the LRU key-value cache with per-entry expiry.
// Depends on lru_kv_pkg, lru_kv_req_if and lru_kv_rsp_if.
//
// Usage:
//   req carries one beat per request: set, get, delete or purge, with the
//   key, the value to store, a ttl in ms (0 = never expires) and the current
//   time. rsp returns one beat per request: hit, read value and the entry
//   count after the request. cfg_wr_en/cfg_wr_data write the capacity
//   register (0 acts as 1, above the slot count acts as the slot count);
//   write it only while no request is in flight.
//   An accepted request runs one scan step per slot over all 16 slots, then
//   an act step that applies the update, an insert step for a set that
//   installs a new key, and a done step that loads the output register;
//   the sequencer then returns to idle before the next request is accepted.
//   The scan over the slots goes through a single compare and rank unit;
//   one request is worked on at a time.
//   The output register holds a finished response while the next request
//   is accepted; a stalled receiver holds the response and, once the next
//   request is done, holds that one back until the output register drains.
//   Reset empties the store (all slots invalid, ranks zero) and sets the
//   capacity to 16.
module lru_ttl_key_value_cache (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [4:0]    cfg_wr_data,
    lru_kv_req_if.sink    req,
    lru_kv_rsp_if.source  rsp
);

    localparam int N  = lru_kv_pkg::ENTRIES;
    localparam int IW = lru_kv_pkg::IDX_BITS;
    localparam int CB = lru_kv_pkg::CNT_BITS;
    localparam int KB = lru_kv_pkg::KEY_BITS;
    localparam int VB = lru_kv_pkg::VALUE_BITS;
    localparam int TB = lru_kv_pkg::TIME_BITS;
    localparam int CW = lru_kv_pkg::COUNT_W;
    localparam int PW = lru_kv_pkg::CAP_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_ACT  = 3'd2;
    localparam logic [2:0] ST_INS  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // rank unit operations
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TOUCH  = 2'd2;
    localparam logic [1:0] OP_INSERT = 2'd3;

    // configuration
    logic [PW-1:0] cap_reg;

    // slot state: control bits in flops, payload in arrays
    logic [N-1:0]  valid_reg;
    logic [IW-1:0] rank_reg [N];
    logic [KB-1:0] key_mem  [N];
    logic [VB-1:0] val_mem  [N];
    logic [TB-1:0] exp_mem  [N];
    logic [CB-1:0] count_reg;

    // sequencer
    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [IW-1:0] idx_reg;
    logic [1:0]    type_reg;
    logic [KB-1:0] key_reg;
    logic [VB-1:0] wval_reg;
    logic [TB-1:0] exp_reg;
    logic [TB-1:0] now_reg;

    // scan results
    logic          found_reg;
    logic [IW-1:0] slot_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_reg;
    logic          vic_found_reg;
    logic [IW-1:0] vic_reg;
    logic [IW-1:0] vic_rank_reg;
    logic [IW-1:0] ins_reg;

    // finished result and output register
    logic          res_hit_reg;
    logic [VB-1:0] res_val_reg;
    logic          out_valid_reg;
    logic          out_hit_reg;
    logic [VB-1:0] out_val_reg;
    logic [CW-1:0] out_cnt_reg;

    logic          accept;
    logic [TB:0]   exp_sum;
    logic [TB-1:0] exp_calc;
    logic          cur_valid;
    logic          cur_match;
    logic          cur_expired;
    logic          slot_expired;
    logic          scan_last;
    logic [CB-1:0] eff_cap;
    logic          evict;
    logic          ins_ok;
    logic [IW-1:0] ins_slot;
    logic [1:0]    op_kind;
    logic [IW-1:0] op_slot;
    logic [IW-1:0] op_rank;
    logic          out_free;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    // expiry = now + ttl, saturating; ttl of zero never expires
    assign exp_sum  = {1'b0, req.now} + (TB + 1)'(req.ttl);
    assign exp_calc = (req.ttl == '0 || exp_sum[TB]) ? '1 : exp_sum[TB-1:0];

    assign cur_valid    = valid_reg[idx_reg];
    assign cur_match    = cur_valid && (key_mem[idx_reg] == key_reg);
    assign cur_expired  = now_reg > exp_mem[idx_reg];
    assign slot_expired = now_reg > exp_mem[slot_reg];
    assign scan_last    = (idx_reg == IW'(N - 1));

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CB'(1);
        end
        else if (int'(cap_reg) > N)
        begin
            eff_cap = CB'(N);
        end
        else
        begin
            eff_cap = CB'(cap_reg);
        end
    end

    // new key: evict the least recent slot first when the store is full
    assign evict = (count_reg >= eff_cap) && vic_found_reg;
    always_comb
    begin
        ins_ok   = free_found_reg || evict;
        ins_slot = free_reg;
        if (evict && !(free_found_reg && (free_reg < vic_reg)))
        begin
            ins_slot = vic_reg;
        end
    end

    // pick the operation of the shared rank unit for this cycle
    always_comb
    begin
        op_kind = OP_NONE;
        op_slot = slot_reg;
        unique case (state_reg)
            ST_SCAN:
            begin
                if (type_reg == lru_kv_pkg::REQ_PURGE && cur_valid && cur_expired)
                begin
                    op_kind = OP_REMOVE;
                    op_slot = idx_reg;
                end
            end
            ST_ACT:
            begin
                case (type_reg)
                    lru_kv_pkg::REQ_SET:
                    begin
                        if (found_reg)
                        begin
                            op_kind = OP_TOUCH;
                        end
                        else if (evict)
                        begin
                            op_kind = OP_REMOVE;
                            op_slot = vic_reg;
                        end
                    end
                    lru_kv_pkg::REQ_GET:
                    begin
                        if (found_reg)
                        begin
                            op_kind = slot_expired ? OP_REMOVE : OP_TOUCH;
                        end
                    end
                    lru_kv_pkg::REQ_DELETE:
                    begin
                        if (found_reg)
                        begin
                            op_kind = OP_REMOVE;
                        end
                    end
                    default:
                    begin
                        op_kind = OP_NONE;
                    end
                endcase
            end
            ST_INS:
            begin
                op_kind = OP_INSERT;
                op_slot = ins_reg;
            end
            default:
            begin
                op_kind = OP_NONE;
            end
        endcase
    end

    assign op_rank = rank_reg[op_slot];

    // rank unit: remove, touch or insert one slot, adjusting all others
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < N; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            case (op_kind)
                OP_REMOVE:
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        if (valid_reg[i] && rank_reg[i] > op_rank)
                        begin
                            rank_reg[i] <= rank_reg[i] - IW'(1);
                        end
                    end
                    valid_reg[op_slot] <= 1'b0;
                    rank_reg[op_slot]  <= '0;
                    count_reg          <= count_reg - CB'(1);
                end
                OP_TOUCH:
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        if (valid_reg[i] && rank_reg[i] < op_rank)
                        begin
                            rank_reg[i] <= rank_reg[i] + IW'(1);
                        end
                    end
                    rank_reg[op_slot] <= '0;
                end
                OP_INSERT:
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        if (valid_reg[i])
                        begin
                            rank_reg[i] <= rank_reg[i] + IW'(1);
                        end
                    end
                    valid_reg[op_slot] <= 1'b1;
                    rank_reg[op_slot]  <= '0;
                    count_reg          <= count_reg + CB'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // slot payload: overwrite on a set of a present key, fill on insert
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACT && type_reg == lru_kv_pkg::REQ_SET && found_reg)
        begin
            val_mem[slot_reg] <= wval_reg;
            exp_mem[slot_reg] <= exp_reg;
        end
        if (state_reg == ST_INS)
        begin
            key_mem[ins_reg] <= key_reg;
            val_mem[ins_reg] <= wval_reg;
            exp_mem[ins_reg] <= exp_reg;
        end
    end

    // request latch, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg <= req.req_type;
            key_reg  <= req.key;
            wval_reg <= req.write_value;
            exp_reg  <= exp_calc;
            now_reg  <= req.now;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SCAN;
            ST_SCAN: if (scan_last) state_next = ST_ACT;
            ST_ACT:
            begin
                if (type_reg == lru_kv_pkg::REQ_SET && !found_reg && ins_ok)
                begin
                    state_next = ST_INS;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_INS:  state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer and scan bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= PW'(16);
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            slot_reg       <= '0;
            free_found_reg <= 1'b0;
            free_reg       <= '0;
            vic_found_reg  <= 1'b0;
            vic_reg        <= '0;
            vic_rank_reg   <= '0;
            ins_reg        <= '0;
            res_hit_reg    <= 1'b0;
            res_val_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg        <= '0;
                    found_reg      <= 1'b0;
                    free_found_reg <= 1'b0;
                    vic_found_reg  <= 1'b0;
                    res_hit_reg    <= 1'b0;
                    res_val_reg    <= '0;
                end
                ST_SCAN:
                begin
                    idx_reg <= idx_reg + IW'(1);
                    if (cur_match && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        slot_reg  <= idx_reg;
                    end
                    if (!cur_valid && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_reg       <= idx_reg;
                    end
                    if (cur_valid && (!vic_found_reg || rank_reg[idx_reg] > vic_rank_reg))
                    begin
                        vic_found_reg <= 1'b1;
                        vic_reg       <= idx_reg;
                        vic_rank_reg  <= rank_reg[idx_reg];
                    end
                end
                ST_ACT:
                begin
                    ins_reg <= ins_slot;
                    if (type_reg == lru_kv_pkg::REQ_GET && found_reg && !slot_expired)
                    begin
                        res_hit_reg <= 1'b1;
                        res_val_reg <= val_mem[slot_reg];
                    end
                    if (type_reg == lru_kv_pkg::REQ_DELETE && found_reg)
                    begin
                        res_hit_reg <= 1'b1;
                    end
                end
                ST_INS:
                begin
                end
                ST_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // output register: load the finished beat when the slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_hit_reg <= res_hit_reg;
            out_val_reg <= res_val_reg;
            out_cnt_reg <= CW'(count_reg);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.read_value  = out_val_reg;
    assign rsp.entry_count = out_cnt_reg;

`ifndef SYNTH
    // the running count always matches the valid bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) == $countones(valid_reg))
        else $error("entry count out of step with valid bits");

    // an accepted request always starts a scan at slot zero
    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN && idx_reg == '0))
        else $error("accepted request did not start a scan");

    // a miss never returns data
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !res_hit_reg) |-> (res_val_reg == '0))
        else $error("miss carries a nonzero value");
`endif

endmodule
